[rtl/kert_pkg.sv]
// Shared types and constants of the key event remap table.
`default_nettype none
package kert_pkg;

	localparam int RULES = 16;
	localparam int IDX_W = (RULES > 1) ? $clog2(RULES) : 1;
	localparam logic [15:0] TYPE_KEY = 16'd1;

	typedef struct packed {
		logic              cmd;
		logic [3:0]        rule_index;
		logic              rule_enable;
		logic [15:0]       ev_type;
		logic [15:0]       ev_code;
		logic signed [31:0] ev_value;
		logic              any_value;
		logic [15:0]       new_code;
		logic signed [31:0] new_value;
		logic              keep_value;
		logic              add_release;
	} kert_item_t;

	typedef struct packed {
		logic [15:0]        out_type;
		logic [15:0]        out_code;
		logic signed [31:0] out_value;
		logic               last;
	} kert_result_t;

	typedef struct packed {
		logic [15:0] cmp_type;
		logic [15:0] cmp_code;
		logic [31:0] cmp_value;
		logic        any_value;
		logic        keep_value;
		logic        add_release;
		logic [15:0] new_code;
		logic [31:0] new_value;
	} kert_rule_t;

	localparam int RULE_W = $bits(kert_rule_t);

	typedef struct packed {
		logic             wr_rule;
		logic             ld_ev;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             emit_hit;
		logic             emit_pass;
		logic             emit_rel;
	} kert_cmd_t;

	typedef struct packed {
		logic hit;
		logic rel;
	} kert_sts_t;

endpackage
`default_nettype wire

[rtl/kert_ram.sv]
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`default_nettype none
module kert_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

[rtl/kert_dp.sv]
// Datapath: rule storage, event register, rule compare and result register.
`default_nettype none
module kert_dp import kert_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire kert_item_t   item,
	input  wire kert_cmd_t    cmd,
	output kert_sts_t         sts,
	output kert_result_t      result,
	output logic              result_stb
);

	logic [RULES-1:0] valid_q;
	logic             valid_s1;
	kert_item_t       ev_q;
	logic [RULE_W-1:0] rd_data;
	kert_rule_t       rule_wr;
	kert_rule_t       rule_rd;
	logic             wr_en;
	logic             hit;
	kert_result_t     result_q;
	logic             stb_q;

	assign wr_en = cmd.wr_rule && (32'(item.rule_index) < RULES);

	always_comb begin
		rule_wr.cmp_type    = item.ev_type;
		rule_wr.cmp_code    = item.ev_code;
		rule_wr.cmp_value   = item.ev_value;
		rule_wr.any_value   = item.any_value;
		rule_wr.keep_value  = item.keep_value;
		rule_wr.add_release = item.add_release;
		rule_wr.new_code    = item.new_code;
		rule_wr.new_value   = item.new_value;
	end

	kert_ram #(
		.WIDTH(RULE_W),
		.DEPTH(RULES)
	) u_rule_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(IDX_W'(item.rule_index)),
		.wr_data(rule_wr),
		.rd_en  (cmd.rd_en),
		.rd_addr(cmd.rd_addr),
		.rd_data(rd_data)
	);

	assign rule_rd = kert_rule_t'(rd_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[IDX_W'(item.rule_index)] <= item.rule_enable;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			valid_s1 <= valid_q[cmd.rd_addr];
		end
		if (cmd.ld_ev) begin
			ev_q <= item;
		end
	end

	assign hit = valid_s1 && (rule_rd.cmp_type == ev_q.ev_type)
		&& (rule_rd.cmp_code == ev_q.ev_code)
		&& (rule_rd.any_value || (rule_rd.cmp_value == ev_q.ev_value));

	assign sts.hit = hit;
	assign sts.rel = rule_rd.add_release;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stb_q <= 1'b0;
		end else begin
			stb_q <= cmd.emit_hit || cmd.emit_pass || cmd.emit_rel;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_hit) begin
			result_q.out_type  <= TYPE_KEY;
			result_q.out_code  <= rule_rd.new_code;
			result_q.out_value <= rule_rd.keep_value ? ev_q.ev_value : rule_rd.new_value;
			result_q.last      <= !rule_rd.add_release;
		end else if (cmd.emit_pass) begin
			result_q.out_type  <= ev_q.ev_type;
			result_q.out_code  <= ev_q.ev_code;
			result_q.out_value <= ev_q.ev_value;
			result_q.last      <= 1'b1;
		end else if (cmd.emit_rel) begin
			result_q.out_value <= '0;
			result_q.last      <= 1'b1;
		end
	end

	assign result     = result_q;
	assign result_stb = stb_q;

endmodule
`default_nettype wire

[rtl/kert_ctrl.sv]
// Controller: accepts beats and steps the rule scan and result sequence.
`default_nettype none
module kert_ctrl import kert_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic       item_cmd,
	input  wire kert_sts_t  sts,
	output logic            busy,
	output kert_cmd_t       cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_REL  = 2'd2;

	logic [1:0]       state_q;
	logic [1:0]       state_d;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] idx_d;
	logic             pend_q;
	logic             pend_d;
	logic             last_q;
	logic             last_d;
	logic             accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		pend_d  = pend_q;
		last_d  = last_q;
		cmd     = '0;
		cmd.rd_addr = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (item_cmd) begin
						cmd.wr_rule = 1'b1;
					end else begin
						cmd.ld_ev = 1'b1;
						idx_d   = '0;
						pend_d  = 1'b0;
						last_d  = 1'b0;
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (pend_q && sts.hit) begin
					cmd.emit_hit = 1'b1;
					state_d = sts.rel ? ST_REL : ST_IDLE;
				end else if (pend_q && last_q) begin
					cmd.emit_pass = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cmd.rd_en = 1'b1;
					pend_d = 1'b1;
					last_d = (idx_q == IDX_W'(RULES - 1));
					idx_d  = idx_q + 1'b1;
				end
			end
			ST_REL: begin
				cmd.emit_rel = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			pend_q  <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			pend_q  <= pend_d;
			last_q  <= last_d;
		end
	end

endmodule
`default_nettype wire

[rtl/key_event_remap_table_core.sv]
// Top level of the key event remap table.
`default_nettype none
// A beat is taken when start is high and busy is low. A rule write (cmd 1)
// keeps busy low and gives no result. An event (cmd 0) scans the rule RAM
// one slot per cycle through its single read port; busy stays high until
// the scan ends and, when a release result follows, through that result.
// Each result appears on result for exactly one cycle with result_stb high,
// in the cycle after the decision, and must be taken then, since the
// receiver cannot stall the block. The valid marks of all rule slots are
// cleared by reset.
module key_event_remap_table_core import kert_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire kert_item_t item,
	output kert_result_t    result,
	output logic            result_stb
);

	kert_cmd_t cmd;
	kert_sts_t sts;

	kert_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.item_cmd(item.cmd),
		.sts     (sts),
		.busy    (busy),
		.cmd     (cmd)
	);

	kert_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (cmd),
		.sts       (sts),
		.result    (result),
		.result_stb(result_stb)
	);

endmodule
`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the key event remap table core: directed and random beats.
module testbench;
	import kert_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = RULES + 4;

	logic         clk;
	logic         arst_n;
	logic         start;
	logic         busy;
	kert_item_t   item;
	kert_result_t result;
	logic         result_stb;

	key_event_remap_table_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.result    (result),
		.result_stb(result_stb)
	);

	kert_item_t   rule_slots [RULES];
	bit           slot_live [RULES];
	kert_result_t remapped_events [$];

	int unsigned cycle_cnt;
	int unsigned mismatch_cnt;
	int unsigned event_cnt;
	int unsigned write_cnt;
	int unsigned rewrite_cnt;
	int unsigned release_cnt;
	int unsigned passthru_cnt;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("status: fail");
			$finish;
		end
	end

	task automatic remap_beat(input kert_item_t it);
		kert_result_t r;
		bit           hit;
		int           i;
		hit = 1'b0;
		if (it.cmd) begin
			write_cnt++;
			if (it.rule_index < RULES) begin
				rule_slots[it.rule_index] = it;
				slot_live[it.rule_index]  = it.rule_enable;
			end
		end else begin
			event_cnt++;
			for (i = 0; i < RULES && !hit; i++) begin
				if (slot_live[i] && rule_slots[i].ev_type == it.ev_type &&
				    rule_slots[i].ev_code == it.ev_code &&
				    (rule_slots[i].any_value ||
				     rule_slots[i].ev_value == it.ev_value)) begin
					hit = 1'b1;
					rewrite_cnt++;
					r.out_type  = TYPE_KEY;
					r.out_code  = rule_slots[i].new_code;
					r.out_value = rule_slots[i].keep_value ? it.ev_value : rule_slots[i].new_value;
					r.last      = !rule_slots[i].add_release;
					remapped_events.insert(remapped_events.size(), r);
					if (rule_slots[i].add_release) begin
						release_cnt++;
						r.out_value = '0;
						r.last      = 1'b1;
						remapped_events.insert(remapped_events.size(), r);
					end
				end
			end
			if (!hit) begin
				passthru_cnt++;
				r.out_type  = it.ev_type;
				r.out_code  = it.ev_code;
				r.out_value = it.ev_value;
				r.last      = 1'b1;
				remapped_events.insert(remapped_events.size(), r);
			end
		end
	endtask

	task automatic flag_mismatch(input string what, input kert_result_t want,
	                             input kert_result_t got);
		mismatch_cnt++;
		if (mismatch_cnt <= 10) begin
			$write("%0s at %0t: expected type %h code %h value %h last %b, ",
			       what, $realtime, want.out_type, want.out_code, want.out_value, want.last);
			$display("got type %h code %h value %h last %b",
			         got.out_type, got.out_code, got.out_value, got.last);
		end
	endtask

	always @(posedge clk) begin
		kert_result_t want;
		if (arst_n === 1'b1 && result_stb === 1'b1) begin
			if (remapped_events.size() == 0) begin
				want = '0;
				flag_mismatch("unexpected result", want, result);
			end else begin
				want = remapped_events.pop_front();
				if (result.out_type !== want.out_type || result.out_code !== want.out_code ||
				    result.out_value !== want.out_value || result.last !== want.last)
					flag_mismatch("wrong result", want, result);
			end
		end
	end

	task automatic send_beat(input kert_item_t it, input bit allow_gap);
		if (allow_gap && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy !== 1'b0);
		remap_beat(it);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (remapped_events.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic kert_item_t make_event(input logic [15:0] typ, input logic [15:0] code,
	                                          input logic [31:0] val);
		kert_item_t      it;
		logic [127:0]    raw;
		raw = {$urandom(), $urandom(), $urandom(), $urandom()};
		it = raw[$bits(kert_item_t)-1:0];
		it.cmd      = 1'b0;
		it.ev_type  = typ;
		it.ev_code  = code;
		it.ev_value = val;
		return it;
	endfunction

	function automatic kert_item_t make_rule(input logic [3:0] idx, input logic en,
	                                         input logic [15:0] typ, input logic [15:0] code,
	                                         input logic [31:0] val, input logic anyv,
	                                         input logic [15:0] ncode, input logic [31:0] nval,
	                                         input logic keep, input logic rel);
		kert_item_t it;
		it.cmd         = 1'b1;
		it.rule_index  = idx;
		it.rule_enable = en;
		it.ev_type     = typ;
		it.ev_code     = code;
		it.ev_value    = val;
		it.any_value   = anyv;
		it.new_code    = ncode;
		it.new_value   = nval;
		it.keep_value  = keep;
		it.add_release = rel;
		return it;
	endfunction

	function automatic kert_item_t random_beat();
		kert_item_t   it;
		logic [127:0] raw;
		int unsigned  s;
		raw = {$urandom(), $urandom(), $urandom(), $urandom()};
		it = raw[$bits(kert_item_t)-1:0];
		it.cmd = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 9) != 0) begin
			it.ev_type = 16'($urandom_range(0, 3));
			it.ev_code = 16'($urandom_range(0, 7));
			case ($urandom_range(0, 3))
				0: it.ev_value = 32'sd0;
				1: it.ev_value = 32'sd1;
				2: it.ev_value = -32'sd1;
				default: ;
			endcase
		end
		if (it.cmd) begin
			it.rule_enable = ($urandom_range(0, 7) != 0);
		end else if ($urandom_range(0, 1) == 1) begin
			s = $urandom_range(0, RULES - 1);
			it.ev_type = rule_slots[s].ev_type;
			it.ev_code = rule_slots[s].ev_code;
			if ($urandom_range(0, 2) != 0)
				it.ev_value = rule_slots[s].ev_value;
		end
		return it;
	endfunction

	task automatic test_empty_passthrough();
		send_beat(make_event(16'h0000, 16'h0000, 32'h0000_0000), 1'b0);
		send_beat(make_event(16'hffff, 16'hffff, 32'h7fff_ffff), 1'b0);
		send_beat(make_event(16'h8000, 16'h0001, 32'h8000_0000), 1'b0);
		send_beat(make_event(16'h0001, 16'h001e, 32'hffff_ffff), 1'b0);
	endtask

	task automatic test_rule_cases();
		send_beat(make_rule(4'd0, 1'b1, 16'd1, 16'd30, 32'd1, 1'b0, 16'd44, 32'h7fff_ffff,
		                    1'b0, 1'b0), 1'b0);
		send_beat(make_event(16'd1, 16'd30, 32'd1), 1'b0);
		send_beat(make_event(16'd1, 16'd30, 32'd2), 1'b0);
		send_beat(make_rule(4'd15, 1'b1, 16'd4, 16'd4, 32'd0, 1'b1, 16'hffff, 32'd0,
		                    1'b1, 1'b1), 1'b0);
		send_beat(make_event(16'd4, 16'd4, 32'hffff_fffb), 1'b0);
		send_beat(make_rule(4'd7, 1'b1, 16'd4, 16'd4, 32'd0, 1'b1, 16'h0000, 32'h8000_0000,
		                    1'b0, 1'b0), 1'b0);
		send_beat(make_event(16'd4, 16'd4, 32'd123), 1'b0);
		send_beat(make_rule(4'd7, 1'b0, 16'd4, 16'd4, 32'd0, 1'b1, 16'h0000, 32'h8000_0000,
		                    1'b0, 1'b0), 1'b0);
		send_beat(make_event(16'd4, 16'd4, 32'd9), 1'b0);
		send_beat(make_rule(4'd3, 1'b1, 16'hffff, 16'hffff, 32'h8000_0000, 1'b0, 16'h1234,
		                    32'h0, 1'b1, 1'b0), 1'b0);
		send_beat(make_event(16'hffff, 16'hffff, 32'h8000_0000), 1'b0);
		send_beat(make_event(16'hffff, 16'hffff, 32'h7fff_ffff), 1'b0);
		send_beat(make_rule(4'd0, 1'b1, 16'd1, 16'd30, 32'd5, 1'b1, 16'h0000, 32'hffff_ffff,
		                    1'b0, 1'b1), 1'b0);
		send_beat(make_event(16'd1, 16'd30, 32'd0), 1'b0);
		// The sender holds off here until every expected result has been seen.
		drain_results();
	endtask

	task automatic test_random_traffic(input int n_beats, input int calm_tail);
		int n;
		for (n = 0; n < n_beats; n++)
			send_beat(random_beat(), n < n_beats - calm_tail);
	endtask

	initial begin
		int i;
		arst_n <= 1'b0;
		start  <= 1'b0;
		item   <= '0;
		for (i = 0; i < RULES; i++) begin
			rule_slots[i] = '0;
			slot_live[i]  = 1'b0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_passthrough();
		test_rule_cases();
		test_random_traffic(1530, 200);
		drain_results();
		$write("covered %0d rule writes and %0d events: ", write_cnt, event_cnt);
		$display("%0d rewritten (%0d with release), %0d passed through",
		         rewrite_cnt, release_cnt, passthru_cnt);
		$display("%0d mismatches, %0d results still expected", mismatch_cnt,
		         remapped_events.size());
		if (mismatch_cnt == 0 && remapped_events.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
